// ----- sv/linear_to_srgb_encode_core_defines.svh -----
// Assertion helpers for the sRGB encode core.
// Both macros sample on aclk and stay quiet while aresetn is low.
`ifndef LINEAR_TO_SRGB_ENCODE_CORE_DEFINES_SVH
`define LINEAR_TO_SRGB_ENCODE_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LTS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("sRGB encode core: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define LTS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("sRGB encode core: next-cycle check failed");

`endif

// ----- sv/lts_pkg.sv -----
package lts_pkg;

    localparam int FRAC_BITS = 16;
    localparam int CH_W      = 17;
    localparam logic [CH_W-1:0] ONE_VAL = CH_W'(longint'(1) << FRAC_BITS);

    // Pseudo-float: value = m * 2^e, m normalized with its top bit set, or zero.
    localparam int MANT_W = 32;
    localparam int EXP_W  = 11;

    typedef struct packed {
        logic [MANT_W-1:0]       m;
        logic signed [EXP_W-1:0] e;
    } pf_t;

    // Binary search state handed from cell to cell.
    typedef struct packed {
        logic [CH_W-1:0] lo;
        logic [CH_W-1:0] hi;
        pf_t             rhs;
    } srch_t;

    typedef struct packed {
        logic [CH_W-1:0] lin_red;
        logic [CH_W-1:0] lin_green;
        logic [CH_W-1:0] lin_blue;
    } pix_in_t;

    typedef struct packed {
        logic [CH_W-1:0] enc_red;
        logic [CH_W-1:0] enc_green;
        logic [CH_W-1:0] enc_blue;
    } pix_out_t;

    localparam int NCELLS    = FRAC_BITS + 1;
    localparam int FRONT_LAT = 5;
    localparam int CELL_LAT  = 5;
    localparam int PIPE_LAT  = FRONT_LAT + NCELLS * CELL_LAT;

    // Linear segment.
    localparam logic [CH_W-1:0] LIN_MAX =
        CH_W'((longint'(31308) << FRAC_BITS) / longint'(10000000));
    localparam int LIN_X_W  = 8;
    localparam int NUM_W    = 19;
    localparam int Q_W      = 12;
    localparam int LIN_MUL  = 1292;
    localparam int LIN_RND  = 50;
    localparam int LIN_DIV  = 100;
    localparam int RECIP    = 41943;
    localparam int RECIP_SH = 22;
    localparam int RECIP_W  = 16;

    // Boundary numerator: 2000 * c - 1000 + 110 * 2^F.
    localparam int N_W   = 28;
    localparam int N_MUL = 2000;
    localparam logic [N_W-1:0] N_OFF = N_W'(110 * (1 << FRAC_BITS) - 1000);
    localparam logic [EXP_W-1:0] LHS_BIAS = EXP_W'(5 * FRAC_BITS);

    function automatic pf_t pf_from(input logic [MANT_W-1:0] v);
        pf_t r;
        int  top;
        top = -1;
        for (int i = 0; i < MANT_W; i++) begin
            if (v[i]) begin
                top = i;
            end
        end
        if (top < 0) begin
            r.m = '0;
            r.e = '0;
        end else begin
            r.m = v << (MANT_W - 1 - top);
            r.e = EXP_W'(top - (MANT_W - 1));
        end
        return r;
    endfunction

    // Product with the mantissa truncated back to MANT_W bits.
    function automatic pf_t pf_mul(input pf_t a, input pf_t b);
        pf_t                  r;
        logic [2*MANT_W-1:0]  p;
        p = {{MANT_W{1'b0}}, a.m} * {{MANT_W{1'b0}}, b.m};
        if (a.m == '0 || b.m == '0) begin
            r.m = '0;
            r.e = '0;
        end else if (p[2*MANT_W-1]) begin
            r.m = p[2*MANT_W-1:MANT_W];
            r.e = a.e + b.e + EXP_W'(MANT_W);
        end else begin
            r.m = p[2*MANT_W-2:MANT_W-1];
            r.e = a.e + b.e + EXP_W'(MANT_W - 1);
        end
        return r;
    endfunction

    function automatic logic pf_le(input pf_t a, input pf_t b);
        logic le;
        if (a.m == '0) begin
            le = 1'b1;
        end else if (b.m == '0) begin
            le = 1'b0;
        end else if (a.e != b.e) begin
            le = ($signed(a.e) < $signed(b.e));
        end else begin
            le = (a.m <= b.m);
        end
        return le;
    endfunction

    // (2110 * 2^F)^12, built exactly as the datapath would.
    localparam pf_t D1  = pf_from(MANT_W'(2110 * (1 << FRAC_BITS)));
    localparam pf_t D2  = pf_mul(D1, D1);
    localparam pf_t D4  = pf_mul(D2, D2);
    localparam pf_t D8  = pf_mul(D4, D4);
    localparam pf_t D12 = pf_mul(D8, D4);

endpackage

// ----- sv/lts_front.sv -----
module lts_front
    import lts_pkg::*;
(
    input  logic            aclk,
    input  logic            en,
    input  logic [CH_W-1:0] lin,
    output srch_t           srch
);

    pf_t                xs1_reg, xs2_reg, xs3_reg;
    pf_t                x2_reg, x4_reg, x5_reg;
    logic               lin1_reg, lin2_reg, lin3_reg, lin4_reg;
    logic [NUM_W-1:0]   num1_reg, num2_reg;
    logic [Q_W-1:0]     q2_reg, res3_reg, res4_reg;
    srch_t              srch_reg;

    logic [CH_W-1:0]    x_clamp;
    logic [NUM_W-1:0]   num_next;
    logic [NUM_W-1:0]   rem;
    logic [NUM_W+RECIP_W-1:0] qprod;

    always_comb begin
        x_clamp  = (lin > ONE_VAL) ? ONE_VAL : lin;
        num_next = NUM_W'(x_clamp[LIN_X_W-1:0]) * NUM_W'(LIN_MUL) + NUM_W'(LIN_RND);
        qprod    = (NUM_W+RECIP_W)'(num1_reg) * (NUM_W+RECIP_W)'(RECIP);
        rem      = num2_reg - NUM_W'(q2_reg) * NUM_W'(LIN_DIV);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            xs1_reg  <= pf_from(MANT_W'(x_clamp));
            lin1_reg <= (x_clamp <= LIN_MAX);
            num1_reg <= num_next;

            x2_reg   <= pf_mul(xs1_reg, xs1_reg);
            xs2_reg  <= xs1_reg;
            lin2_reg <= lin1_reg;
            num2_reg <= num1_reg;
            q2_reg   <= Q_W'(qprod >> RECIP_SH);

            // The reciprocal estimate is at most one low.
            x4_reg   <= pf_mul(x2_reg, x2_reg);
            xs3_reg  <= xs2_reg;
            lin3_reg <= lin2_reg;
            res3_reg <= (rem >= NUM_W'(LIN_DIV)) ? q2_reg + 1'b1 : q2_reg;

            x5_reg   <= pf_mul(x4_reg, xs3_reg);
            lin4_reg <= lin3_reg;
            res4_reg <= res3_reg;

            // A linear-segment channel enters the search already settled.
            srch_reg <= '{lo:  lin4_reg ? CH_W'(res4_reg) : CH_W'(0),
                          hi:  lin4_reg ? CH_W'(res4_reg) : ONE_VAL,
                          rhs: pf_mul(x5_reg, D12)};
        end
    end

    assign srch = srch_reg;

endmodule

// ----- sv/lts_cell.sv -----
module lts_cell
    import lts_pkg::*;
(
    input  logic  aclk,
    input  logic  en,
    input  srch_t srch_in,
    output srch_t srch_out
);

    srch_t           s1_reg, s2_reg, s3_reg, s4_reg, out_reg;
    logic [CH_W-1:0] mid1_reg, mid2_reg, mid3_reg, mid4_reg;
    pf_t             n1_reg, n1b_reg, n2_reg, n3_reg, n6_reg;

    logic [CH_W-1:0] span;
    logic [CH_W-1:0] mid;
    logic [N_W-1:0]  nval;
    pf_t             lhs;
    logic            fits;
    srch_t           out_next;

    always_comb begin
        span  = srch_in.hi - srch_in.lo + 1'b1;
        mid   = srch_in.lo + (span >> 1);
        nval  = N_W'(mid) * N_W'(N_MUL) + N_OFF;
        lhs   = pf_mul(n6_reg, n6_reg);
        lhs.e = lhs.e + LHS_BIAS;
        fits  = pf_le(lhs, s4_reg.rhs);
        out_next = s4_reg;
        if (s4_reg.lo < s4_reg.hi) begin
            if (fits) begin
                out_next.lo = mid4_reg;
            end else begin
                out_next.hi = mid4_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_reg   <= srch_in;
            mid1_reg <= mid;
            n1_reg   <= pf_from(MANT_W'(nval));

            s2_reg   <= s1_reg;
            mid2_reg <= mid1_reg;
            n2_reg   <= pf_mul(n1_reg, n1_reg);
            n1b_reg  <= n1_reg;

            s3_reg   <= s2_reg;
            mid3_reg <= mid2_reg;
            n3_reg   <= pf_mul(n2_reg, n1b_reg);

            s4_reg   <= s3_reg;
            mid4_reg <= mid3_reg;
            n6_reg   <= pf_mul(n3_reg, n3_reg);

            out_reg  <= out_next;
        end
    end

    assign srch_out = out_reg;

endmodule

// ----- sv/linear_to_srgb_encode_core.sv -----
// sRGB encoder: linear-light RGB in, sRGB-encoded RGB out, one pixel per transfer.
// Input channel s_valid/s_ready/s_data carries three unsigned Q16 channels
// (0 to 1.0, where 65536 is 1.0); output channel m_valid/m_ready/m_data carries
// the encoded channels in the same format, saturated at 1.0.
// Each channel runs through a front stage that forms x^5 scaled by a constant,
// then through a row of seventeen identical search cells, each settling one
// step of a binary search on the output code. A pixel passes through 90
// pipeline stages and then the output register before m_valid rises.
// Throughput is one pixel per cycle while the pipeline is not stopped.
// When the receiver stalls, the output register holds its pixel; the pipeline
// keeps moving while its last stage is empty, and stops (s_ready low) only when
// a finished pixel would have to overwrite the one still waiting.
// Synchronous active-low reset empties the pipeline and the output register;
// datapath registers are not reset.
module linear_to_srgb_encode_core
    import lts_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  pix_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output pix_out_t m_data
);

    // One valid flag per pipeline stage, shifted along with the data.
    logic [PIPE_LAT-1:0] vld_reg;
    logic [PIPE_LAT-1:0] vld_next;
    logic                out_valid_reg;
    pix_out_t            out_data_reg;
    logic                adv;

    logic [CH_W-1:0] lin_ch [3];
    srch_t           srch   [3][NCELLS+1];

    // The chain advances unless a finished pixel would land on a waiting one.
    assign adv     = !(out_valid_reg && !m_ready && vld_reg[PIPE_LAT-1]);
    assign s_ready = adv;

    assign lin_ch[0] = s_data.lin_red;
    assign lin_ch[1] = s_data.lin_green;
    assign lin_ch[2] = s_data.lin_blue;

    for (genvar ch = 0; ch < 3; ch++) begin : g_ch
        lts_front u_front (
            .aclk (aclk),
            .en   (adv),
            .lin  (lin_ch[ch]),
            .srch (srch[ch][0])
        );
        for (genvar k = 0; k < NCELLS; k++) begin : g_cell
            lts_cell u_cell (
                .aclk     (aclk),
                .en       (adv),
                .srch_in  (srch[ch][k]),
                .srch_out (srch[ch][k+1])
            );
        end
    end

    assign vld_next = {vld_reg[PIPE_LAT-2:0], s_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (adv) begin
                vld_reg <= vld_next;
            end
            if (adv && vld_reg[PIPE_LAT-1]) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // At the end of the row the search has closed, so lo is the code.
    always_ff @(posedge aclk) begin
        if (adv && vld_reg[PIPE_LAT-1]) begin
            out_data_reg.enc_red   <= srch[0][NCELLS].lo;
            out_data_reg.enc_green <= srch[1][NCELLS].lo;
            out_data_reg.enc_blue  <= srch[2][NCELLS].lo;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

`include "linear_to_srgb_encode_core_defines.svh"

    // Every pixel leaving the row must have a fully closed search interval.
    `LTS_ASSERT_NOW(a_search_closed, vld_reg[PIPE_LAT-1], (srch[0][NCELLS].lo == srch[0][NCELLS].hi) && (srch[1][NCELLS].lo == srch[1][NCELLS].hi) && (srch[2][NCELLS].lo == srch[2][NCELLS].hi))

    // Encoded codes never pass 1.0.
    `LTS_ASSERT_NOW(a_out_range, m_valid, (m_data.enc_red <= ONE_VAL) && (m_data.enc_green <= ONE_VAL) && (m_data.enc_blue <= ONE_VAL))

    // A finished pixel is only moved out when the output register is free.
    `LTS_ASSERT_NOW(a_no_overwrite, adv && vld_reg[PIPE_LAT-1], !out_valid_reg || m_ready)

    // An accepted transfer occupies the first stage in the next cycle.
    `LTS_ASSERT_NEXT(a_enter, s_valid && s_ready, vld_reg[0])

endmodule
